[rtl/core/shq_pkg.sv]
// ----------------------------------------------------------------------------
// shq_pkg
// Types and constants shared by the scan hit qualifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shq_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned FREQ_W  = 27;
    localparam int unsigned QUOT_W  = 21;   // floor(2^27 / 100) fits in 21 bits
    localparam int unsigned REM_W   = 7;    // remainder modulo 100

    localparam logic [TIME_W-1:0] HOLD_MS   = 32'd500;
    localparam logic [TIME_W-1:0] SWITCH_MS = 32'd700;
    localparam logic [FREQ_W-1:0] BCAST_LO  = 27'd8800000;
    localparam logic [FREQ_W-1:0] BCAST_HI  = 27'd10800000;
    localparam logic [FREQ_W-1:0] LOCK_STEP = 27'd100;
    localparam logic [REM_W-1:0]  HALF_STEP = 7'd50;

    // floor(n / 25) = (n * RECIP_25) >> 30, exact for any 25-bit n
    localparam int unsigned       RECIP_W     = 26;
    localparam int unsigned       RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_25   = 26'd42949673;

    typedef enum logic [2:0] {
        ACT_HELD    = 3'd0,
        ACT_SWITCH  = 3'd1,
        ACT_WAIT    = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_CAND    = 3'd4,
        ACT_LOCK    = 3'd5
    } action_t;

    typedef struct packed {
        logic              lower_sel;
        logic [FREQ_W-1:0] candidate_freq;
        logic [TIME_W-1:0] last_switch_ms;
        logic              scan_active;
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              listening;
        logic              activity_valid;
        logic [TIME_W-1:0] activity_time_ms;
        logic              result_ready;
        logic [FREQ_W-1:0] scan_freq;
        logic              freq_blocked;
        logic [QUOT_W-1:0] scan_quot;   // scan_freq / 100, taken at capture
    } item_t;

    typedef struct packed {
        action_t           action;
        logic              lower_band;
        logic [FREQ_W-1:0] tuned_freq;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/scan_hit_qualifier_core.sv]
// ----------------------------------------------------------------------------
// scan_hit_qualifier_core
// Qualifies scanner hits per service tick and locks onto repeated hits.
// ----------------------------------------------------------------------------
// Path: an accepted request goes through the input register, then the result
//   register, which holds it while m_ready is low.
// Throughput: one request per cycle while m_ready holds no result back; the state
//   update sits in the single stage between the input and result registers.
// Reset: aresetn synchronous active low; clears both stage valids, band_bound,
//   and state to lower band, no candidate, last switch 0, scan not armed.
`default_nettype none

module scan_hit_qualifier_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    // band_bound write port
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [shq_pkg::FREQ_W-1:0]  cfg_wdata,

    // tick requests
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [shq_pkg::TIME_W-1:0]  s_now_ms,
    input  wire logic                        s_listening,
    input  wire logic                        s_activity_valid,
    input  wire logic [shq_pkg::TIME_W-1:0]  s_activity_time_ms,
    input  wire logic                        s_result_ready,
    input  wire logic [shq_pkg::FREQ_W-1:0]  s_scan_freq,
    input  wire logic                        s_freq_blocked,

    // results
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [2:0]                       m_action,
    output logic                             m_lower_band,
    output logic [shq_pkg::FREQ_W-1:0]       m_tuned_freq
);

    localparam int unsigned PROD_W = (shq_pkg::FREQ_W - 2) + shq_pkg::RECIP_W;

    logic [shq_pkg::FREQ_W-1:0] band_bound_reg;

    logic                       in_valid_reg;
    shq_pkg::item_t             in_item_reg;
    shq_pkg::item_t             in_item_next;

    logic                       out_valid_reg;
    shq_pkg::result_t           out_res_reg;
    shq_pkg::result_t           step_res;

    shq_pkg::state_t            state_reg;
    shq_pkg::state_t            state_next;

    logic                       advance;
    logic                       s_accept;
    logic [PROD_W-1:0]          recip_prod;

    // The item in the input register commits its state update as it moves
    // into the result register, so the next item always sees current state.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // f / 100 = (f >> 2) / 25 via reciprocal multiply, done at capture so the
    // stage only needs a shift-add and a subtract for the remainder.
    assign recip_prod = PROD_W'(s_scan_freq[shq_pkg::FREQ_W-1:2]) * PROD_W'(shq_pkg::RECIP_25);

    always_comb begin
        in_item_next.now_ms           = s_now_ms;
        in_item_next.listening        = s_listening;
        in_item_next.activity_valid   = s_activity_valid;
        in_item_next.activity_time_ms = s_activity_time_ms;
        in_item_next.result_ready     = s_result_ready;
        in_item_next.scan_freq        = s_scan_freq;
        in_item_next.freq_blocked     = s_freq_blocked;
        in_item_next.scan_quot        =
            recip_prod[shq_pkg::RECIP_SHIFT +: shq_pkg::QUOT_W];
    end

    shq_step u_step (
        .cur_state  (state_reg),
        .item       (in_item_reg),
        .band_bound (band_bound_reg),
        .nxt_state  (state_next),
        .result     (step_res)
    );

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            band_bound_reg           <= '0;
            state_reg.lower_sel      <= 1'b1;
            state_reg.candidate_freq <= '0;
            state_reg.last_switch_ms <= '0;
            state_reg.scan_active    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                band_bound_reg <= cfg_wdata;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_action     = out_res_reg.action;
    assign m_lower_band = out_res_reg.lower_band;
    assign m_tuned_freq = out_res_reg.tuned_freq;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_tuned_only_on_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (out_res_reg.action != shq_pkg::ACT_LOCK) |-> m_tuned_freq == '0)
        else $error("tuned frequency nonzero without lock");

    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item advancing");

    a_lock_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (step_res.action == shq_pkg::ACT_LOCK) |=> !state_reg.scan_active)
        else $error("scan still armed after lock");

    a_switch_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (step_res.action == shq_pkg::ACT_SWITCH)
        |=> state_reg.scan_active && (state_reg.lower_sel != $past(state_reg.lower_sel)))
        else $error("band switch did not toggle band and arm scan");

    a_band_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_lower_band == state_reg.lower_sel)
        else $error("reported band differs from state");

endmodule

`default_nettype wire

[rtl/core/shq_step.sv]
// ----------------------------------------------------------------------------
// shq_step
// Per-tick decision logic: hold, band switch, wait, restart, qualify and lock.
// ----------------------------------------------------------------------------
`default_nettype none

module shq_step (
    input  wire shq_pkg::state_t             cur_state,
    input  wire shq_pkg::item_t              item,
    input  wire logic [shq_pkg::FREQ_W-1:0]  band_bound,
    output shq_pkg::state_t                  nxt_state,
    output shq_pkg::result_t                 result
);

    logic [shq_pkg::TIME_W-1:0] act_age;
    logic [shq_pkg::TIME_W-1:0] switch_age;
    logic                       hold;
    logic [shq_pkg::FREQ_W-1:0] freq;
    logic                       in_bcast;
    logic                       wrong_side;
    logic                       qualified;
    logic [shq_pkg::FREQ_W-1:0] cand_diff;
    logic [shq_pkg::FREQ_W-1:0] quot_x100;
    logic [shq_pkg::REM_W-1:0]  rem;
    logic [shq_pkg::FREQ_W-1:0] rounded;
    logic [shq_pkg::FREQ_W-1:0] rem_full;

    assign act_age    = item.now_ms - item.activity_time_ms;
    assign switch_age = item.now_ms - cur_state.last_switch_ms;
    assign hold       = item.listening || (item.activity_valid && (act_age < shq_pkg::HOLD_MS));

    // an unarmed scan ignores whatever the scanner reports
    assign freq       = cur_state.scan_active ? item.scan_freq : '0;
    assign in_bcast   = (freq >= shq_pkg::BCAST_LO) && (freq < shq_pkg::BCAST_HI);
    assign wrong_side = cur_state.lower_sel ? (freq >= band_bound) : (freq < band_bound);
    assign qualified  = (freq != '0) && !in_bcast && !wrong_side && !item.freq_blocked;

    assign cand_diff  = (freq > cur_state.candidate_freq) ? freq - cur_state.candidate_freq
                                                          : cur_state.candidate_freq - freq;

    // q*100 as shift-add: 64q + 32q + 4q
    assign quot_x100 = {item.scan_quot, 6'b0} + {1'b0, item.scan_quot, 5'b0}
                     + {4'b0, item.scan_quot, 2'b0};
    assign rem_full  = item.scan_freq - quot_x100;
    assign rem       = rem_full[shq_pkg::REM_W-1:0];
    assign rounded   = (rem > shq_pkg::HALF_STEP) ? quot_x100 + shq_pkg::LOCK_STEP : quot_x100;

    always_comb begin
        nxt_state         = cur_state;
        result.action     = shq_pkg::ACT_HELD;
        result.tuned_freq = '0;
        if (hold) begin
            result.action = shq_pkg::ACT_HELD;
        end else if (switch_age >= shq_pkg::SWITCH_MS) begin
            nxt_state.lower_sel      = !cur_state.lower_sel;
            nxt_state.scan_active    = 1'b1;
            nxt_state.last_switch_ms = item.now_ms;
            result.action            = shq_pkg::ACT_SWITCH;
        end else if (cur_state.scan_active && !item.result_ready) begin
            result.action = shq_pkg::ACT_WAIT;
        end else begin
            nxt_state.scan_active = 1'b1;
            result.action         = shq_pkg::ACT_RESTART;
            if (qualified) begin
                if (cand_diff < shq_pkg::LOCK_STEP) begin
                    // freq is the raw scan_freq here, so the rounding applies to it
                    result.tuned_freq     = rounded;
                    nxt_state.scan_active = 1'b0;
                    result.action         = shq_pkg::ACT_LOCK;
                end else begin
                    nxt_state.candidate_freq = freq;
                    result.action            = shq_pkg::ACT_CAND;
                end
            end
        end
        result.lower_band = nxt_state.lower_sel;
    end

endmodule

`default_nettype wire
